### design/turn_then_drive_goal_controller_core_macros.svh
// Assertion macros shared by the go-to-goal controller RTL.
`ifndef TURN_THEN_DRIVE_GOAL_CONTROLLER_CORE_MACROS_SVH
`define TURN_THEN_DRIVE_GOAL_CONTROLLER_CORE_MACROS_SVH
`ifndef SYNTHESIS
`define TTDGC_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
`define TTDGC_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define TTDGC_ASSERT_IMP(label, clk, rst_n, ante, cons, msg)
`define TTDGC_ASSERT_NXT(label, clk, rst_n, ante, cons, msg)
`endif
`endif

### design/ttdgc_pkg.sv
// Types, constants and the arctangent table of the go-to-goal controller.
package ttdgc_pkg;

    localparam int COORD_W  = 16;
    localparam int OFS_W    = 17;
    localparam int CORDIC_W = 27;
    localparam int MAG_W    = 26;
    localparam int ANG_W    = 32;
    localparam int GAIN_W   = 16;
    localparam int PROD_W   = MAG_W + GAIN_W;
    localparam int DIST_W   = 18;
    localparam int ADV_W    = 12;
    localparam int ITER_W   = 5;
    localparam int PRESCALE = 8;
    localparam int DIV_CNT_W = 4;
    localparam int PADDR_W  = 4;
    localparam int PDATA_W  = 32;

    localparam logic [GAIN_W-1:0] INV_GAIN = 16'd39797;
    localparam logic [ANG_W-1:0]  ANG_PI   = 32'h8000_0000;
    localparam logic [ANG_W-1:0]  ANG_HALF_PI = 32'h4000_0000;
    localparam logic [ANG_W-1:0]  ANG_ROUND = 32'h0000_8000;
    localparam logic [PROD_W:0]   MAG_ROUND = 43'h000_0080_0000;
    localparam logic [DIV_CNT_W-1:0] DIV_LAST_BIT = 4'd11;

    localparam logic OP_TARGET = 1'b0;
    localparam logic OP_POSE   = 1'b1;

    localparam logic [1:0] PH_ALIGN = 2'd0;
    localparam logic [1:0] PH_DRIVE = 2'd1;
    localparam logic [1:0] PH_STOP  = 2'd2;

    localparam logic [1:0] REG_MAX_SPEED       = 2'd0;
    localparam logic [1:0] REG_SLOW_RADIUS     = 2'd1;
    localparam logic [1:0] REG_ARRIVE_DISTANCE = 2'd2;
    localparam logic [1:0] REG_ALIGN_THRESHOLD = 2'd3;

    localparam logic [11:0] RST_MAX_SPEED       = 12'd1000;
    localparam logic [15:0] RST_SLOW_RADIUS     = 16'd1000;
    localparam logic [15:0] RST_ARRIVE_DISTANCE = 16'd50;
    localparam logic [14:0] RST_ALIGN_THRESHOLD = 15'd939;

    typedef struct packed {
        logic                       opcode;
        logic signed [COORD_W-1:0]  target_x;
        logic signed [COORD_W-1:0]  target_z;
        logic signed [COORD_W-1:0]  robot_x;
        logic signed [COORD_W-1:0]  robot_z;
        logic signed [COORD_W-1:0]  robot_heading;
    } in_item_t;

    typedef struct packed {
        logic [ADV_W-1:0]           advance_speed;
        logic signed [COORD_W-1:0]  rotation_cmd;
        logic [1:0]                 phase_out;
        logic                       task_done;
    } out_item_t;

    typedef struct packed {
        logic load;
        logic step;
    } cordic_ctrl_t;

    typedef struct packed {
        logic busy;
        logic last;
    } cordic_stat_t;

    function automatic logic [ANG_W-1:0] atan_entry(input logic [ITER_W-1:0] idx);
        logic [ANG_W-1:0] v;
        case (idx)
            5'd0:    v = 32'd536870912;
            5'd1:    v = 32'd316933406;
            5'd2:    v = 32'd167458907;
            5'd3:    v = 32'd85004756;
            5'd4:    v = 32'd42667331;
            5'd5:    v = 32'd21354465;
            5'd6:    v = 32'd10679838;
            5'd7:    v = 32'd5340245;
            5'd8:    v = 32'd2670163;
            5'd9:    v = 32'd1335087;
            5'd10:   v = 32'd667544;
            5'd11:   v = 32'd333772;
            5'd12:   v = 32'd166886;
            5'd13:   v = 32'd83443;
            5'd14:   v = 32'd41722;
            5'd15:   v = 32'd20861;
            5'd16:   v = 32'd10430;
            5'd17:   v = 32'd5215;
            5'd18:   v = 32'd2608;
            5'd19:   v = 32'd1304;
            5'd20:   v = 32'd652;
            5'd21:   v = 32'd326;
            5'd22:   v = 32'd163;
            5'd23:   v = 32'd81;
            default: v = 32'd0;
        endcase
        return v;
    endfunction

endpackage

### design/turn_then_drive_goal_controller_core.sv
// Top level of the turn-then-drive go-to-goal controller with its register port.
//
//   Port group  Direction  Handshake          Beat
//   s_          in         s_valid / s_ready  opcode, target and pose
//   m_          out        m_valid / m_ready  advance, rotation, phase, done
//   p*          in/out     APB, pready high   configuration registers
//
// A pose beat that needs arithmetic goes through the shared CORDIC stage, and in
// drive also through the bit-serial divider when the distance is under the slow
// radius. Reset is synchronous and needs no clearing pass. A held result does not
// block the next beat, but a finished one waits on m_ready.
`include "turn_then_drive_goal_controller_core_macros.svh"
module turn_then_drive_goal_controller_core #(
    parameter int CORDIC_ITERATIONS = 16
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                s_valid,
    output logic                                s_ready,
    input  ttdgc_pkg::in_item_t                 s_data,
    output logic                                m_valid,
    input  logic                                m_ready,
    output ttdgc_pkg::out_item_t                m_data,
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [ttdgc_pkg::PADDR_W-1:0]       paddr,
    input  logic [ttdgc_pkg::PDATA_W-1:0]       pwdata,
    output logic [ttdgc_pkg::PDATA_W-1:0]       prdata,
    output logic                                pready
);

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_ROT  = 3'd1;
    localparam logic [2:0] S_MAG  = 3'd2;
    localparam logic [2:0] S_DIST = 3'd3;
    localparam logic [2:0] S_EVAL = 3'd4;
    localparam logic [2:0] S_DIVI = 3'd5;
    localparam logic [2:0] S_DIV  = 3'd6;
    localparam logic [2:0] S_FIN  = 3'd7;

    logic [2:0]  state_reg, state_next;
    logic [11:0] max_speed_reg, max_speed_next;
    logic [15:0] slow_radius_reg, slow_radius_next;
    logic [15:0] arrive_distance_reg, arrive_distance_next;
    logic [14:0] align_threshold_reg, align_threshold_next;
    logic signed [15:0] goal_x_reg, goal_x_next;
    logic signed [15:0] goal_z_reg, goal_z_next;
    logic        active_reg, active_next;
    logic [1:0]  phase_reg, phase_next;
    logic [15:0] head_reg, head_next;
    logic [ttdgc_pkg::PROD_W-1:0]    prod_reg, prod_next;
    logic [ttdgc_pkg::DIST_W-1:0]    dist_reg, dist_next;
    logic [15:0] b16_reg, b16_next;
    logic [15:0] rem_reg, rem_next;
    logic [ttdgc_pkg::DIV_CNT_W-1:0] cnt_reg, cnt_next;
    logic [ttdgc_pkg::ADV_W-1:0]     adv_reg, adv_next;
    logic        m_valid_reg, m_valid_next;
    ttdgc_pkg::out_item_t m_data_reg, m_data_next;

    logic        s_fire, cfg_we, out_free;
    logic signed [ttdgc_pkg::OFS_W-1:0] dx, dz;
    ttdgc_pkg::cordic_ctrl_t cordic_ctrl;
    ttdgc_pkg::cordic_stat_t cordic_stat;
    logic [ttdgc_pkg::MAG_W-1:0] mag_raw;
    logic [ttdgc_pkg::ANG_W-1:0] cordic_angle;
    logic [ttdgc_pkg::MAG_W-1:0]  mul_a;
    logic [ttdgc_pkg::GAIN_W-1:0] mul_b;
    logic [ttdgc_pkg::PROD_W-1:0] mul_p;
    logic [ttdgc_pkg::PROD_W:0]   mag_sum;
    logic [ttdgc_pkg::ANG_W-1:0]  b32, b32_round;
    logic [15:0] bmag;
    logic [16:0] div_trial;
    logic [11:0] div_low;
    logic        pose_work;

    assign s_ready  = (state_reg == S_IDLE);
    assign s_fire   = s_valid && s_ready;
    assign cfg_we   = psel && penable && pwrite;
    assign pready   = 1'b1;
    assign out_free = !m_valid_reg || m_ready;

    assign dx = $signed({goal_x_reg[15], goal_x_reg}) - $signed({s_data.robot_x[15], s_data.robot_x});
    assign dz = $signed({goal_z_reg[15], goal_z_reg}) - $signed({s_data.robot_z[15], s_data.robot_z});
    assign pose_work = (s_data.opcode == ttdgc_pkg::OP_POSE) && active_reg
                       && ((phase_reg == ttdgc_pkg::PH_ALIGN) || (phase_reg == ttdgc_pkg::PH_DRIVE));

    assign cordic_ctrl.load = s_fire && pose_work && ((dx != '0) || (dz != '0));
    assign cordic_ctrl.step = (state_reg == S_ROT);

    ttdgc_cordic #(
        .ITERATIONS (CORDIC_ITERATIONS)
    ) u_cordic (
        .aclk    (aclk),
        .aresetn (aresetn),
        .ctrl    (cordic_ctrl),
        .dx      (dx),
        .dz      (dz),
        .mag_raw (mag_raw),
        .angle   (cordic_angle),
        .stat    (cordic_stat)
    );

    always_comb begin
        if (state_reg == S_MAG) begin
            mul_a = mag_raw;
            mul_b = ttdgc_pkg::INV_GAIN;
        end else begin
            mul_a = {{(ttdgc_pkg::MAG_W - ttdgc_pkg::ADV_W){1'b0}}, max_speed_reg};
            mul_b = dist_reg[15:0];
        end
    end
    assign mul_p = mul_a * mul_b;

    assign mag_sum   = {1'b0, prod_reg} + ttdgc_pkg::MAG_ROUND;
    assign b32       = ttdgc_pkg::ANG_HALF_PI - cordic_angle - {head_reg, 16'h0000};
    assign b32_round = b32 + ttdgc_pkg::ANG_ROUND;
    assign bmag      = b16_reg[15] ? (16'd0 - b16_reg) : b16_reg;
    assign div_low   = prod_reg[11:0];
    assign div_trial = {rem_reg, div_low[cnt_reg]};

    always_comb begin
        prdata = '0;
        case (paddr[3:2])
            ttdgc_pkg::REG_MAX_SPEED:       prdata = {20'd0, max_speed_reg};
            ttdgc_pkg::REG_SLOW_RADIUS:     prdata = {16'd0, slow_radius_reg};
            ttdgc_pkg::REG_ARRIVE_DISTANCE: prdata = {16'd0, arrive_distance_reg};
            ttdgc_pkg::REG_ALIGN_THRESHOLD: prdata = {17'd0, align_threshold_reg};
            default:                        prdata = '0;
        endcase
    end

    always_comb begin
        max_speed_next       = max_speed_reg;
        slow_radius_next     = slow_radius_reg;
        arrive_distance_next = arrive_distance_reg;
        align_threshold_next = align_threshold_reg;
        if (cfg_we) begin
            case (paddr[3:2])
                ttdgc_pkg::REG_MAX_SPEED:       max_speed_next       = pwdata[11:0];
                ttdgc_pkg::REG_SLOW_RADIUS:     slow_radius_next     = pwdata[15:0];
                ttdgc_pkg::REG_ARRIVE_DISTANCE: arrive_distance_next = pwdata[15:0];
                ttdgc_pkg::REG_ALIGN_THRESHOLD: align_threshold_next = pwdata[14:0];
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        state_next   = state_reg;
        goal_x_next  = goal_x_reg;
        goal_z_next  = goal_z_reg;
        active_next  = active_reg;
        phase_next   = phase_reg;
        head_next    = head_reg;
        prod_next    = prod_reg;
        dist_next    = dist_reg;
        b16_next     = b16_reg;
        rem_next     = rem_reg;
        cnt_next     = cnt_reg;
        adv_next     = adv_reg;
        m_valid_next = m_valid_reg && !m_ready;
        m_data_next  = m_data_reg;

        case (state_reg)
            S_IDLE: begin
                if (s_fire) begin
                    if (s_data.opcode == ttdgc_pkg::OP_TARGET) begin
                        goal_x_next = s_data.target_x;
                        goal_z_next = s_data.target_z;
                        active_next = 1'b1;
                        phase_next  = ttdgc_pkg::PH_ALIGN;
                    end else if (active_reg) begin
                        head_next = s_data.robot_heading;
                        if (!pose_work) begin
                            state_next = S_FIN;
                        end else if (cordic_ctrl.load) begin
                            state_next = S_ROT;
                        end else begin
                            dist_next  = '0;
                            b16_next   = '0;
                            state_next = S_EVAL;
                        end
                    end
                end
            end
            S_ROT: begin
                if (cordic_stat.last) begin
                    state_next = S_MAG;
                end
            end
            S_MAG: begin
                prod_next  = mul_p;
                state_next = S_DIST;
            end
            S_DIST: begin
                dist_next  = mag_sum[ttdgc_pkg::PROD_W-1:24];
                b16_next   = b32_round[31:16];
                state_next = S_EVAL;
            end
            S_EVAL: begin
                if (phase_reg == ttdgc_pkg::PH_ALIGN) begin
                    state_next = S_FIN;
                end else if ((slow_radius_reg == '0) || (dist_reg >= {2'b00, slow_radius_reg})) begin
                    adv_next   = max_speed_reg;
                    state_next = S_FIN;
                end else begin
                    prod_next  = mul_p;
                    state_next = S_DIVI;
                end
            end
            S_DIVI: begin
                rem_next   = prod_reg[27:12];
                cnt_next   = ttdgc_pkg::DIV_LAST_BIT;
                adv_next   = '0;
                state_next = S_DIV;
            end
            S_DIV: begin
                if (div_trial >= {1'b0, slow_radius_reg}) begin
                    rem_next = 16'(div_trial - {1'b0, slow_radius_reg});
                    adv_next = {adv_reg[ttdgc_pkg::ADV_W-2:0], 1'b1};
                end else begin
                    rem_next = div_trial[15:0];
                    adv_next = {adv_reg[ttdgc_pkg::ADV_W-2:0], 1'b0};
                end
                if (cnt_reg == '0) begin
                    state_next = S_FIN;
                end else begin
                    cnt_next = cnt_reg - 1'b1;
                end
            end
            S_FIN: begin
                if (out_free) begin
                    m_valid_next = 1'b1;
                    state_next   = S_IDLE;
                    case (phase_reg)
                        ttdgc_pkg::PH_ALIGN: begin
                            m_data_next.advance_speed = '0;
                            m_data_next.rotation_cmd  = b16_reg;
                            m_data_next.phase_out     = ttdgc_pkg::PH_ALIGN;
                            m_data_next.task_done     = 1'b0;
                            if (bmag <= {1'b0, align_threshold_reg}) begin
                                phase_next = ttdgc_pkg::PH_DRIVE;
                            end
                        end
                        ttdgc_pkg::PH_DRIVE: begin
                            m_data_next.advance_speed = adv_reg;
                            m_data_next.rotation_cmd  = b16_reg;
                            m_data_next.phase_out     = ttdgc_pkg::PH_DRIVE;
                            m_data_next.task_done     = 1'b0;
                            if (dist_reg < {2'b00, arrive_distance_reg}) begin
                                phase_next = ttdgc_pkg::PH_STOP;
                            end
                        end
                        default: begin
                            m_data_next.advance_speed = '0;
                            m_data_next.rotation_cmd  = '0;
                            m_data_next.phase_out     = ttdgc_pkg::PH_STOP;
                            m_data_next.task_done     = 1'b1;
                            active_next = 1'b0;
                            phase_next  = ttdgc_pkg::PH_STOP;
                        end
                    endcase
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg           <= S_IDLE;
            max_speed_reg       <= ttdgc_pkg::RST_MAX_SPEED;
            slow_radius_reg     <= ttdgc_pkg::RST_SLOW_RADIUS;
            arrive_distance_reg <= ttdgc_pkg::RST_ARRIVE_DISTANCE;
            align_threshold_reg <= ttdgc_pkg::RST_ALIGN_THRESHOLD;
            goal_x_reg          <= '0;
            goal_z_reg          <= '0;
            active_reg          <= 1'b0;
            phase_reg           <= ttdgc_pkg::PH_ALIGN;
            m_valid_reg         <= 1'b0;
        end else begin
            state_reg           <= state_next;
            max_speed_reg       <= max_speed_next;
            slow_radius_reg     <= slow_radius_next;
            arrive_distance_reg <= arrive_distance_next;
            align_threshold_reg <= align_threshold_next;
            goal_x_reg          <= goal_x_next;
            goal_z_reg          <= goal_z_next;
            active_reg          <= active_next;
            phase_reg           <= phase_next;
            m_valid_reg         <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        head_reg   <= head_next;
        prod_reg   <= prod_next;
        dist_reg   <= dist_next;
        b16_reg    <= b16_next;
        rem_reg    <= rem_next;
        cnt_reg    <= cnt_next;
        adv_reg    <= adv_next;
        m_data_reg <= m_data_next;
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    `TTDGC_ASSERT_IMP(a_rot_busy, aclk, aresetn, state_reg == S_ROT, cordic_stat.busy, "CORDIC idle during rotation")
    `TTDGC_ASSERT_NXT(a_target_arms, aclk, aresetn, s_fire && (s_data.opcode == ttdgc_pkg::OP_TARGET), active_reg && (phase_reg == ttdgc_pkg::PH_ALIGN), "New target did not arm align phase")
    `TTDGC_ASSERT_IMP(a_done_is_stop, aclk, aresetn, m_valid && m_data.task_done, (m_data.phase_out == ttdgc_pkg::PH_STOP) && (m_data.advance_speed == '0) && (m_data.rotation_cmd == '0), "Done beat is not a zero stop command")
    `TTDGC_ASSERT_IMP(a_align_still, aclk, aresetn, m_valid && (m_data.phase_out == ttdgc_pkg::PH_ALIGN), (m_data.advance_speed == '0) && !m_data.task_done, "Align beat carries advance or done")

endmodule

### design/ttdgc_cordic.sv
// Iterative vectoring CORDIC giving the angle and raw magnitude of an offset.
module ttdgc_cordic #(
    parameter int ITERATIONS = 16
) (
    input  logic                                    aclk,
    input  logic                                    aresetn,
    input  ttdgc_pkg::cordic_ctrl_t                 ctrl,
    input  logic signed [ttdgc_pkg::OFS_W-1:0]      dx,
    input  logic signed [ttdgc_pkg::OFS_W-1:0]      dz,
    output logic [ttdgc_pkg::MAG_W-1:0]             mag_raw,
    output logic [ttdgc_pkg::ANG_W-1:0]             angle,
    output ttdgc_pkg::cordic_stat_t                 stat
);

    localparam logic [ttdgc_pkg::ITER_W-1:0] LAST_ITER = ttdgc_pkg::ITER_W'(ITERATIONS - 1);

    logic signed [ttdgc_pkg::CORDIC_W-1:0] x_reg, x_next;
    logic signed [ttdgc_pkg::CORDIC_W-1:0] y_reg, y_next;
    logic [ttdgc_pkg::ANG_W-1:0]           ang_reg, ang_next;
    logic [ttdgc_pkg::ITER_W-1:0]          iter_reg, iter_next;
    logic                                  running_reg, running_next;
    logic signed [ttdgc_pkg::CORDIC_W-1:0] x_init, y_init;
    logic signed [ttdgc_pkg::CORDIC_W-1:0] x_shift, y_shift;
    logic [ttdgc_pkg::ANG_W-1:0]           atan_val;
    logic                                  last_step;

    assign x_init = {{(ttdgc_pkg::CORDIC_W - ttdgc_pkg::OFS_W - ttdgc_pkg::PRESCALE){dx[ttdgc_pkg::OFS_W-1]}},
                     dx, {ttdgc_pkg::PRESCALE{1'b0}}};
    assign y_init = {{(ttdgc_pkg::CORDIC_W - ttdgc_pkg::OFS_W - ttdgc_pkg::PRESCALE){dz[ttdgc_pkg::OFS_W-1]}},
                     dz, {ttdgc_pkg::PRESCALE{1'b0}}};
    assign x_shift  = x_reg >>> iter_reg;
    assign y_shift  = y_reg >>> iter_reg;
    assign atan_val = ttdgc_pkg::atan_entry(iter_reg);
    assign last_step = running_reg && (iter_reg == LAST_ITER);

    always_comb begin
        x_next       = x_reg;
        y_next       = y_reg;
        ang_next     = ang_reg;
        iter_next    = iter_reg;
        running_next = running_reg;
        if (ctrl.load) begin
            running_next = 1'b1;
            iter_next    = '0;
            if (dx < 0) begin
                x_next   = -x_init;
                y_next   = -y_init;
                ang_next = ttdgc_pkg::ANG_PI;
            end else begin
                x_next   = x_init;
                y_next   = y_init;
                ang_next = '0;
            end
        end else if (ctrl.step && running_reg) begin
            if (y_reg > 0) begin
                x_next   = x_reg + y_shift;
                y_next   = y_reg - x_shift;
                ang_next = ang_reg + atan_val;
            end else begin
                x_next   = x_reg - y_shift;
                y_next   = y_reg + x_shift;
                ang_next = ang_reg - atan_val;
            end
            if (last_step) begin
                running_next = 1'b0;
            end else begin
                iter_next = iter_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            running_reg <= 1'b0;
            iter_reg    <= '0;
        end else begin
            running_reg <= running_next;
            iter_reg    <= iter_next;
        end
    end

    always_ff @(posedge aclk) begin
        x_reg   <= x_next;
        y_reg   <= y_next;
        ang_reg <= ang_next;
    end

    assign mag_raw   = x_reg[ttdgc_pkg::MAG_W-1:0];
    assign angle     = ang_reg;
    assign stat.busy = running_reg;
    assign stat.last = last_step;

endmodule
